@@ hdl/prb_pkg.sv @@
package prb_pkg;

	localparam int WINDOW     = 32;
	localparam int IDX_W      = $clog2(WINDOW);
	localparam int CNT_W      = $clog2(WINDOW + 1);
	localparam int SEQ_W      = 16;
	localparam int TAG_W      = 32;
	localparam int THR_W      = 5;
	localparam int CMP_W      = 16;

	localparam logic [THR_W-1:0] SKIP_RESET = THR_W'(25);
	localparam logic [SEQ_W-1:0] HEADER_SEQ = SEQ_W'(0);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_LOAD  = 5'b00100,
		ST_FLUSH = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

endpackage

@@ hdl/packet_reorder_buffer_unit.sv @@
// A request that releases packets is accepted and then scanned; each released packet adds
// a scan and a payload read, each skip a scan; output stalls hold the load and flush steps.
// A request that releases nothing goes through accept, scan, flush and done, and a header
// request is only accepted; a new request is taken only in idle.
// Reset (arst_n, asynchronous, active low) clears control state, slot valid bits and the
// threshold (25); the payload memory is not cleared, so there is no clearing pass.
module packet_reorder_buffer_unit
	import prb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SEQ_W-1:0] seq_num,
	input  logic [TAG_W-1:0] payload_tag,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [THR_W-1:0] cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SEQ_W-1:0] out_seq,
	output logic [TAG_W-1:0] out_payload,
	output logic             last
);

	// Control state of the window. The slot for sequence s sits at
	// (head + (s - expected)) mod WINDOW, so head always is the slot of the expected number.
	state_t            state_q;
	logic [SEQ_W-1:0]  expected_q;
	logic [IDX_W-1:0]  head_q;
	logic              started_q;
	logic [CNT_W-1:0]  pending_q;
	logic [WINDOW-1:0] valid_q;
	logic [THR_W-1:0]  thr_q;

	// Payload store: one synchronous memory, read data registered.
	logic [TAG_W-1:0]  mem [WINDOW];
	logic [TAG_W-1:0]  rd_data_q;
	logic [SEQ_W-1:0]  ld_seq_q;

	// A released packet is held back one step, because only the next scan tells
	// whether it is the last one of this request.
	logic              hold_valid_q;
	logic [SEQ_W-1:0]  hold_seq_q;
	logic [TAG_W-1:0]  hold_payload_q;

	// Output register.
	logic              out_valid_q;
	logic [SEQ_W-1:0]  out_seq_q;
	logic [TAG_W-1:0]  out_payload_q;
	logic              out_last_q;

	logic              in_fire;
	logic              is_header;
	logic [SEQ_W-1:0]  exp_eff;
	logic [IDX_W-1:0]  head_eff;
	logic [SEQ_W-1:0]  seq_ahead;
	logic              in_window;
	logic [IDX_W:0]    idx_sum;
	logic [IDX_W-1:0]  wr_idx;
	logic              wr_en;
	logic              new_slot;
	logic [IDX_W-1:0]  head_next;
	logic              over_thr;
	logic              out_free;
	logic              push;
	logic              rd_en;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign is_header = (seq_num == HEADER_SEQ);

	// The first packet fixes the expected number and the ring base.
	assign exp_eff   = started_q ? expected_q : seq_num;
	assign head_eff  = started_q ? head_q : '0;
	assign seq_ahead = seq_num - exp_eff;
	assign in_window = (seq_ahead < SEQ_W'(WINDOW));
	assign idx_sum   = {1'b0, head_eff} + {1'b0, seq_ahead[IDX_W-1:0]};
	assign wr_idx    = (idx_sum >= (IDX_W+1)'(WINDOW)) ?
		IDX_W'(idx_sum - (IDX_W+1)'(WINDOW)) : idx_sum[IDX_W-1:0];
	assign wr_en     = in_fire && !is_header && in_window;
	assign new_slot  = wr_en && !valid_q[wr_idx];

	assign head_next = (head_q == IDX_W'(WINDOW - 1)) ? '0 : head_q + IDX_W'(1);
	assign over_thr  = (CMP_W'(pending_q) > CMP_W'(thr_q));

	assign rd_en     = (state_q == ST_SCAN) && (pending_q != '0) && valid_q[head_q];
	assign out_free  = !out_valid_q || out_ready;
	assign push      = hold_valid_q && out_free &&
		((state_q == ST_LOAD) || (state_q == ST_FLUSH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= payload_tag;
		end
		if (rd_en) begin
			rd_data_q <= mem[head_q];
			ld_seq_q  <= expected_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			expected_q   <= '0;
			head_q       <= '0;
			started_q    <= 1'b0;
			pending_q    <= '0;
			valid_q      <= '0;
			thr_q        <= SKIP_RESET;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end

			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire && !is_header) begin
						started_q  <= 1'b1;
						expected_q <= exp_eff;
						head_q     <= head_eff;
						if (new_slot) begin
							valid_q[wr_idx] <= 1'b1;
							pending_q       <= pending_q + CNT_W'(1);
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (pending_q == '0) begin
						state_q <= ST_FLUSH;
					end else if (valid_q[head_q]) begin
						// Release the expected packet; its payload arrives next cycle.
						valid_q[head_q] <= 1'b0;
						pending_q       <= pending_q - CNT_W'(1);
						expected_q      <= expected_q + SEQ_W'(1);
						head_q          <= head_next;
						state_q         <= ST_LOAD;
					end else if (over_thr) begin
						// Too much is waiting behind a gap: give up on the missing number.
						expected_q <= expected_q + SEQ_W'(1);
						head_q     <= head_next;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_LOAD: begin
					if (!hold_valid_q || out_free) begin
						hold_valid_q   <= 1'b1;
						hold_seq_q     <= ld_seq_q;
						hold_payload_q <= rd_data_q;
						state_q        <= ST_SCAN;
					end
				end
				ST_FLUSH: begin
					if (!hold_valid_q || out_free) begin
						hold_valid_q <= 1'b0;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The held packet goes out marked last only when the scan ended.
	always_ff @(posedge clk) begin
		if (push) begin
			out_seq_q     <= hold_seq_q;
			out_payload_q <= hold_payload_q;
			out_last_q    <= (state_q == ST_FLUSH);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_seq     = out_seq_q;
	assign out_payload = out_payload_q;
	assign last        = out_last_q;

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(pending_q))
		else $error("pending count does not match slot valid bits");

	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !hold_valid_q)
		else $error("new request accepted while a released packet is still held");

	a_packet_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (seq_num != HEADER_SEQ)) |=> (state_q == ST_SCAN))
		else $error("accepted packet did not start a scan");

	a_load_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (state_q == ST_LOAD) && (pending_q == $past(pending_q) - CNT_W'(1)))
		else $error("slot release did not go to the payload load");
`endif

endmodule
